FILE: src/clti_pkg.sv
// shared types and constants for the consensus log term index block
package clti_pkg;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_SYNC     = 3'd1,
    OP_TRUNCATE = 3'd2,
    OP_LOOKUP   = 3'd3,
    OP_COMMIT   = 3'd4,
    OP_HARD     = 3'd5,
    OP_BAD      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_RULE  = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } bk_state_t;

  localparam logic [2:0] ACT_APPEND   = 3'd0;
  localparam logic [2:0] ACT_SYNC     = 3'd1;
  localparam logic [2:0] ACT_TRUNCATE = 3'd2;
  localparam logic [2:0] ACT_LOOKUP   = 3'd3;
  localparam logic [2:0] ACT_COMMIT   = 3'd4;
  localparam logic [2:0] ACT_HARD     = 3'd5;

  localparam logic [3:0] ADDR_BASE_INDEX = 4'd0;
  localparam logic [3:0] ADDR_BASE_TERM  = 4'd8;

  typedef struct packed {
    op_t         op;
    logic        ge;
    logic [63:0] d;
    logic [63:0] term;
    logic [63:0] candidate;
    logic        cast_vote;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
    logic [63:0] tail_idx;
    logic [63:0] tail_term;
    logic [63:0] cur_term;
    logic [63:0] ballot;
    logic        has_vote;
    logic [63:0] commit_idx;
  } res_t;

endpackage

FILE: src/clti_ram.sv
// generic single-port-write ram with registered read
module clti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/clti_front.sv
// front end: accepts items, decodes the action, offsets the index, queues them
module clti_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [63:0]        in_index,
  input  logic [63:0]        in_term,
  input  logic [63:0]        in_candidate,
  input  logic               in_cast_vote,
  input  logic [63:0]        snap_idx,
  output logic               q_valid,
  output clti_pkg::item_t    q_item,
  input  logic               q_pop
);
  import clti_pkg::*;

  item_t       ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       it;
  logic        push;

  always_comb begin
    unique case (in_action)
      ACT_APPEND:   it.op = OP_APPEND;
      ACT_SYNC:     it.op = OP_SYNC;
      ACT_TRUNCATE: it.op = OP_TRUNCATE;
      ACT_LOOKUP:   it.op = OP_LOOKUP;
      ACT_COMMIT:   it.op = OP_COMMIT;
      ACT_HARD:     it.op = OP_HARD;
      default:      it.op = OP_BAD;
    endcase
    it.ge        = in_index >= snap_idx;
    it.d         = in_index - snap_idx;
    it.term      = in_term;
    it.candidate = in_candidate;
    it.cast_vote = in_cast_vote;
  end

  assign in_stall = cnt_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= it;
    end
  end

endmodule

FILE: src/clti_back.sv
// back end: executes queued items against the term table and log state
module clti_back #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  clti_pkg::item_t q_item,
  output logic            q_pop,
  input  logic [63:0]     snap_idx,
  input  logic [63:0]     snap_term,
  input  logic            reinit,
  input  logic [63:0]     init_term,
  output logic            out_valid,
  input  logic            out_stall,
  output clti_pkg::res_t  out_res
);
  import clti_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RD = (MAX_ENTRIES > 1) ? MAX_ENTRIES : 2;

  bk_state_t   state_r, state_nxt;
  item_t       cur_r, it;
  logic [CW-1:0] cnt_r, cnt_nxt, commit_r, commit_nxt;
  logic [63:0] newest_r, newest_nxt, durable_r, durable_nxt, vote_r, vote_nxt;
  logic        vote_v_r, vote_v_nxt, unsync_r, unsync_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;

  logic        go, need_rd, finish, we;
  logic [AW-1:0] raddr, waddr;
  logic [63:0] rdata, cnt64, last, value;
  logic [CW-1:0] off, cnt_new, cnt_inc;
  status_t     status;
  logic        owned, trunc_in;

  clti_ram #(.WIDTH(64), .DEPTH(RD)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (it.term),
    .re    (go && need_rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign it      = (state_r == BK_READ) ? cur_r : q_item;
  assign cnt64   = 64'(cnt_r);
  assign last    = snap_idx + cnt64;
  assign off     = it.d[CW-1:0];
  assign cnt_new = off - CW'(1);
  assign cnt_inc = cnt_r + CW'(1);
  assign owned   = it.ge && (it.d <= cnt64);
  assign trunc_in = it.ge && (it.d != 64'd0) && (it.d <= cnt64 + 64'd1);
  assign go      = (state_r == BK_IDLE) && q_valid && (!out_valid_r || !out_stall);
  assign q_pop   = go;
  assign finish  = (go && !need_rd) || (state_r == BK_READ);
  assign waddr   = cnt_r[AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (go && need_rd) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // execution
  always_comb begin
    need_rd    = 1'b0;
    raddr      = AW'(off - CW'(1));
    status     = ST_OK;
    value      = 64'd0;
    we         = 1'b0;
    cnt_nxt    = cnt_r;
    commit_nxt = commit_r;
    newest_nxt = newest_r;
    durable_nxt = durable_r;
    vote_nxt   = vote_r;
    vote_v_nxt = vote_v_r;
    unsync_nxt = unsync_r;
    unique case (it.op)
      OP_APPEND: begin
        if (it.term < newest_r || it.term > durable_r) begin
          status = ST_RULE;
        end else if (cnt_r >= CW'(MAX_ENTRIES) || last == '1) begin
          status = ST_RANGE;
        end else begin
          we         = finish;
          value      = last + 64'd1;
          cnt_nxt    = cnt_inc;
          newest_nxt = it.term;
          unsync_nxt = 1'b1;
        end
      end
      OP_SYNC: unsync_nxt = 1'b0;
      OP_TRUNCATE: begin
        raddr = AW'(off - CW'(2));
        if (!trunc_in) begin
          status = ST_RANGE;
        end else if (unsync_r) begin
          status = ST_RULE;
        end else if (off == cnt_inc) begin
          status = ST_OK;
        end else if (off <= commit_r) begin
          status = ST_RULE;
        end else begin
          cnt_nxt = cnt_new;
          if (cnt_new == '0) begin
            newest_nxt = snap_term;
          end else begin
            need_rd    = 1'b1;
            newest_nxt = rdata;
          end
        end
      end
      OP_LOOKUP: begin
        if (!owned) begin
          status = ST_RANGE;
        end else if (off == '0) begin
          value = snap_term;
        end else begin
          need_rd = 1'b1;
          value   = rdata;
        end
      end
      OP_COMMIT: begin
        if (!owned) begin
          status = ST_RANGE;
        end else if (off < commit_r) begin
          status = ST_RULE;
        end else begin
          commit_nxt = off;
        end
      end
      OP_HARD: begin
        if (it.term < durable_r) begin
          status = ST_RULE;
        end else if (it.term == durable_r) begin
          if (it.cast_vote && vote_v_r && it.candidate != vote_r) begin
            status = ST_RULE;
          end else begin
            if (it.cast_vote) begin
              vote_nxt   = it.candidate;
              vote_v_nxt = 1'b1;
            end
            unsync_nxt = 1'b0;
          end
        end else begin
          durable_nxt = it.term;
          vote_v_nxt  = it.cast_vote;
          vote_nxt    = it.cast_vote ? it.candidate : 64'd0;
          unsync_nxt  = 1'b0;
        end
      end
      default: status = ST_RANGE;
    endcase

    res_nxt.status     = status;
    res_nxt.value      = value;
    res_nxt.tail_idx   = snap_idx + 64'(cnt_nxt);
    res_nxt.tail_term  = newest_nxt;
    res_nxt.cur_term   = durable_nxt;
    res_nxt.ballot     = vote_v_nxt ? vote_nxt : 64'd0;
    res_nxt.has_vote   = vote_v_nxt;
    res_nxt.commit_idx = snap_idx + 64'(commit_nxt);

    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      commit_r    <= '0;
      newest_r    <= 64'd0;
      durable_r   <= 64'd0;
      vote_r      <= 64'd0;
      vote_v_r    <= 1'b0;
      unsync_r    <= 1'b0;
    end else if (reinit) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      commit_r    <= '0;
      newest_r    <= init_term;
      durable_r   <= init_term;
      vote_r      <= 64'd0;
      vote_v_r    <= 1'b0;
      unsync_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        cnt_r     <= cnt_nxt;
        commit_r  <= commit_nxt;
        newest_r  <= newest_nxt;
        durable_r <= durable_nxt;
        vote_r    <= vote_nxt;
        vote_v_r  <= vote_v_nxt;
        unsync_r  <= unsync_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cur_r <= q_item;
    end
    if (finish) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

FILE: src/consensus_log_term_index.sv
// top level of the consensus log term index block
// Keeps the term of every log entry above a snapshot base plus the last term,
// current term, vote and commit index of a consensus log.
// Input channel in_*: one operation per transfer (append, sync, truncate,
// term lookup, set commit, set hard state); result channel out_*: one
// status and state snapshot per operation, in order.
// A front end decodes each operation into a two-deep queue; a back end
// executes it against the term table ram and the state registers.
// Each operation is registered in the queue, then run by the back end into the
// result register; table reads in lookups and truncates add the registered ram
// read. Throughput: one item per cycle of the back end when not stalled, plus a
// read state per table read; the queue keeps input transfers going while a
// result waits. When out_stall is high the result register holds, the back end
// stops and the queue fills, then in_stall rises.
// Reset clears base index and base term and empties the log; the table ram
// is not cleared. A write of either snapshot register over the apb port
// empties the log and reloads last and current term from the base term.
module consensus_log_term_index #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_index,
  input  logic [63:0] in_term,
  input  logic [63:0] in_candidate,
  input  logic        in_cast_vote,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_value,
  output logic [63:0] out_last_index,
  output logic [63:0] out_last_term,
  output logic [63:0] out_current_term,
  output logic [63:0] out_voted_for,
  output logic        out_has_vote,
  output logic [63:0] out_commit_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import clti_pkg::*;

  logic [63:0] snap_idx_r, snap_idx_nxt, snap_term_r, snap_term_nxt;
  logic        wr;
  logic        q_valid, q_pop;
  item_t       q_item;
  res_t        res;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = paddr[3] ? snap_term_r : snap_idx_r;

  always_comb begin
    snap_idx_nxt  = snap_idx_r;
    snap_term_nxt = snap_term_r;
    if (wr) begin
      if (paddr[3]) begin
        snap_term_nxt = pwdata;
      end else begin
        snap_idx_nxt = pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_idx_r  <= 64'd0;
      snap_term_r <= 64'd0;
    end else begin
      snap_idx_r  <= snap_idx_nxt;
      snap_term_r <= snap_term_nxt;
    end
  end

  clti_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_index     (in_index),
    .in_term      (in_term),
    .in_candidate (in_candidate),
    .in_cast_vote (in_cast_vote),
    .snap_idx     (snap_idx_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  clti_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .snap_idx   (snap_idx_r),
    .snap_term  (snap_term_r),
    .reinit     (wr),
    .init_term  (snap_term_nxt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_status       = res.status;
  assign out_value        = res.value;
  assign out_last_index   = res.tail_idx;
  assign out_last_term    = res.tail_term;
  assign out_current_term = res.cur_term;
  assign out_voted_for    = res.ballot;
  assign out_has_vote     = res.has_vote;
  assign out_commit_index = res.commit_idx;

endmodule

FILE: tb/tb_consensus_log_term_index.sv
// testbench for the consensus log term index block: directed table plus predicted random ops
`timescale 1ns / 1ps

module tb_consensus_log_term_index;
  import clti_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [63:0] in_index = '0;
  logic [63:0] in_term = '0;
  logic [63:0] in_candidate = '0;
  logic        in_cast_vote = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_value;
  logic [63:0] out_last_index;
  logic [63:0] out_last_term;
  logic [63:0] out_current_term;
  logic [63:0] out_voted_for;
  logic        out_has_vote;
  logic [63:0] out_commit_index;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  consensus_log_term_index dut (.*);

  always #5 clk = ~clk;

  // log state mirror
  logic [63:0] base_idx, base_trm;
  logic [63:0] entry_terms [TABLE_DEPTH];
  logic [63:0] n_entries, commit_off;
  logic [63:0] newest, durable, vote_node;
  bit          vote_held, dirty;

  res_t        pending_results[$];
  int          errors = 0;
  int unsigned cycle_no = 0;
  int unsigned quiet_cycles = 0;

  typedef struct {
    logic [2:0]  action;
    logic [63:0] index;
    logic [63:0] term;
    logic [63:0] cand;
    logic        cast;
    bit          typed;
    logic [1:0]  exp_status;
    logic [63:0] exp_value;
  } row_t;

  function automatic bit calm();
    return (cycle_no % 4000) >= 2000 && (cycle_no % 4000) < 2700;
  endfunction

  function automatic void empty_log();
    n_entries = 0;
    commit_off = 0;
    newest = base_trm;
    durable = base_trm;
    vote_node = 0;
    vote_held = 0;
    dirty = 0;
  endfunction

  function automatic res_t run_op(logic [2:0] action, logic [63:0] idx, logic [63:0] trm,
                                  logic [63:0] cand, logic cast);
    res_t r;
    logic [63:0] last, d;
    logic [1:0] st;
    st = ST_OK;
    r.value = 0;
    last = base_idx + n_entries;
    d = idx - base_idx;
    case (action)
      ACT_APPEND: begin
        if (trm < newest || trm > durable) st = ST_RULE;
        else if (n_entries >= TABLE_DEPTH || last == ALL_ONES) st = ST_RANGE;
        else begin
          entry_terms[n_entries] = trm;
          n_entries++;
          newest = trm;
          dirty = 1;
          r.value = last + 1;
        end
      end
      ACT_SYNC: dirty = 0;
      ACT_TRUNCATE: begin
        if (idx <= base_idx || d > n_entries + 1) st = ST_RANGE;
        else if (dirty) st = ST_RULE;
        else if (d == n_entries + 1) ;
        else if (d <= commit_off) st = ST_RULE;
        else begin
          n_entries = d - 1;
          newest = (n_entries == 0) ? base_trm : entry_terms[n_entries - 1];
        end
      end
      ACT_LOOKUP: begin
        if (idx < base_idx || d > n_entries) st = ST_RANGE;
        else r.value = (d == 0) ? base_trm : entry_terms[d - 1];
      end
      ACT_COMMIT: begin
        if (idx < base_idx || d > n_entries) st = ST_RANGE;
        else if (d < commit_off) st = ST_RULE;
        else commit_off = d;
      end
      ACT_HARD: begin
        if (trm < durable) st = ST_RULE;
        else if (trm == durable) begin
          if (cast && vote_held && cand != vote_node) st = ST_RULE;
          else begin
            if (cast) begin
              vote_node = cand;
              vote_held = 1;
            end
            dirty = 0;
          end
        end else begin
          durable = trm;
          vote_held = cast;
          vote_node = cast ? cand : 64'd0;
          dirty = 0;
        end
      end
      default: st = ST_RANGE;
    endcase
    r.status = status_t'(st);
    r.tail_idx = base_idx + n_entries;
    r.tail_term = newest;
    r.cur_term = durable;
    r.ballot = vote_held ? vote_node : 64'd0;
    r.has_vote = vote_held;
    r.commit_idx = base_idx + commit_off;
    return r;
  endfunction

  // drives one operation, returns once its transfer happened
  task automatic send_op(logic [2:0] action, logic [63:0] idx, logic [63:0] trm,
                         logic [63:0] cand, logic cast, output res_t predicted);
    while (!calm() && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_index <= idx;
    in_term <= trm;
    in_candidate <= cand;
    in_cast_vote <= cast;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = run_op(action, idx, trm, cand, cast);
    pending_results.push_back(predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_BASE_INDEX) base_idx = data;
    else base_trm = data;
    empty_log();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] near_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return base_idx + n_entries + 64'd1 - 64'($urandom_range(0, 4));
    if (r < 85) return base_idx + 64'($urandom_range(0, 32'(n_entries) + 1));
    if (r < 92) return base_idx - 64'($urandom_range(0, 1));
    return rand64();
  endfunction

  task automatic random_op(int unsigned append_pct);
    res_t p;
    logic [2:0] a;
    logic [63:0] idx, trm, cand, span;
    logic cast;
    int unsigned r;
    r = $urandom_range(0, 99);
    idx = near_index();
    cand = 64'($urandom_range(0, 3));
    cast = 1'($urandom_range(0, 1));
    span = durable - newest;
    trm = newest + ((span > 1000) ? 64'($urandom_range(0, 1000))
                                  : 64'($urandom_range(0, 32'(span))));
    if (r < append_pct) a = ACT_APPEND;
    else begin
      case ($urandom_range(0, 11))
        0, 1: a = ACT_SYNC;
        2, 3: a = ACT_TRUNCATE;
        4, 5: a = ACT_LOOKUP;
        6, 7: a = ACT_COMMIT;
        8, 9, 10: begin
          a = ACT_HARD;
          trm = (durable == ALL_ONES) ? durable : durable + 64'($urandom_range(0, 1));
          if ($urandom_range(0, 9) == 0) trm = durable - 64'd1;
        end
        default: a = 3'($urandom_range(0, 7));
      endcase
    end
    if ($urandom_range(0, 19) == 0) begin
      trm = rand64();
      cand = rand64();
      if ($urandom_range(0, 3) == 0) idx = rand64();
    end
    send_op(a, idx, trm, cand, cast, p);
  endtask

  task automatic random_phase(logic [63:0] bi, logic [63:0] bt, int n, int unsigned pct);
    drain();
    reg_write(ADDR_BASE_INDEX, bi);
    reg_write(ADDR_BASE_TERM, bt);
    repeat (n) random_op(pct);
  endtask

  // result side: stall and compare
  always @(posedge clk) begin
    res_t e;
    cycle_no <= cycle_no + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, status %0d", $realtime,
                 out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $realtime, e.status, out_status);
          errors++;
        end
        if (out_value !== e.value) begin
          $display("%0t: value expected %h got %h", $realtime, e.value, out_value);
          errors++;
        end
        if (out_last_index !== e.tail_idx) begin
          $display("%0t: tail index expected %h got %h", $realtime, e.tail_idx,
                   out_last_index);
          errors++;
        end
        if (out_last_term !== e.tail_term) begin
          $display("%0t: tail term expected %h got %h", $realtime, e.tail_term,
                   out_last_term);
          errors++;
        end
        if (out_current_term !== e.cur_term) begin
          $display("%0t: current term expected %h got %h", $realtime, e.cur_term,
                   out_current_term);
          errors++;
        end
        if (out_voted_for !== e.ballot) begin
          $display("%0t: vote expected %h got %h", $realtime, e.ballot,
                   out_voted_for);
          errors++;
        end
        if (out_has_vote !== e.has_vote) begin
          $display("%0t: has_vote expected %0d got %0d", $realtime, e.has_vote,
                   out_has_vote);
          errors++;
        end
        if (out_commit_index !== e.commit_idx) begin
          $display("%0t: commit index expected %h got %h", $realtime, e.commit_idx,
                   out_commit_index);
          errors++;
        end
      end
    end
    out_stall <= !calm() && $urandom_range(0, 99) < 11;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  row_t rows[] = '{
    '{ACT_APPEND,   64'd0, 64'd0, 64'd0, 1'b0, 1, ST_OK,    64'd1},
    '{ACT_APPEND,   64'd0, 64'd1, 64'd0, 1'b0, 1, ST_RULE,  64'd0},
    '{ACT_HARD,     64'd0, 64'd5, 64'd7, 1'b1, 1, ST_OK,    64'd0},
    '{ACT_HARD,     64'd0, 64'd5, 64'd8, 1'b1, 1, ST_RULE,  64'd0},
    '{ACT_HARD,     64'd0, 64'd5, 64'd9, 1'b0, 1, ST_OK,    64'd0},
    '{ACT_HARD,     64'd0, 64'd4, 64'd7, 1'b1, 1, ST_RULE,  64'd0},
    '{ACT_APPEND,   64'd0, 64'd5, 64'd0, 1'b0, 1, ST_OK,    64'd2},
    '{ACT_TRUNCATE, 64'd2, 64'd0, 64'd0, 1'b0, 1, ST_RULE,  64'd0},
    '{ACT_SYNC,     64'd0, 64'd0, 64'd0, 1'b0, 1, ST_OK,    64'd0},
    '{ACT_LOOKUP,   64'd0, 64'd0, 64'd0, 1'b0, 1, ST_OK,    64'd0},
    '{ACT_LOOKUP,   64'd2, 64'd0, 64'd0, 1'b0, 1, ST_OK,    64'd5},
    '{ACT_LOOKUP,   64'd3, 64'd0, 64'd0, 1'b0, 1, ST_RANGE, 64'd0},
    '{ACT_COMMIT,   64'd1, 64'd0, 64'd0, 1'b0, 1, ST_OK,    64'd0},
    '{ACT_COMMIT,   64'd0, 64'd0, 64'd0, 1'b0, 1, ST_RULE,  64'd0},
    '{ACT_TRUNCATE, 64'd1, 64'd0, 64'd0, 1'b0, 1, ST_RULE,  64'd0},
    '{ACT_TRUNCATE, 64'd0, 64'd0, 64'd0, 1'b0, 1, ST_RANGE, 64'd0},
    '{ACT_TRUNCATE, 64'd3, 64'd0, 64'd0, 1'b0, 1, ST_OK,    64'd0},
    '{ACT_TRUNCATE, 64'd2, 64'd0, 64'd0, 1'b0, 0, ST_OK,    64'd0},
    '{ACT_TRUNCATE, 64'd4, 64'd0, 64'd0, 1'b0, 1, ST_RANGE, 64'd0},
    '{3'd6,         ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1, ST_RANGE, 64'd0},
    '{3'd7,         64'd0, 64'd0, 64'd0, 1'b0, 1, ST_RANGE, 64'd0},
    '{ACT_HARD,     64'd0, ALL_ONES, ALL_ONES, 1'b1, 1, ST_OK, 64'd0},
    '{ACT_APPEND,   64'd0, ALL_ONES, 64'd0, 1'b0, 1, ST_OK,    64'd2},
    '{ACT_LOOKUP,   ALL_ONES, 64'd0, 64'd0, 1'b0, 1, ST_RANGE, 64'd0}
  };

  initial begin
    res_t p;
    base_idx = 0;
    base_trm = 0;
    empty_log();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_op(rows[i].action, rows[i].index, rows[i].term, rows[i].cand, rows[i].cast, p);
      if (rows[i].typed && (p.status !== rows[i].exp_status || p.value !== rows[i].exp_value))
      begin
        $display("%0t: table row %0d expected %0d/%h, predicted %0d/%h", $realtime, i,
                 rows[i].exp_status, rows[i].exp_value, p.status, p.value);
        errors++;
      end
    end
    random_phase(64'd0, ALL_ONES, 150, 40);
    random_phase(ALL_ONES - 3, 64'd10, 100, 45);
    random_phase(rand64() >> 1, 64'd0, 1100, 80);
    random_phase(rand64(), rand64(), 80, 40);
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
